/* src/ssrs_pkg.sv */
// ----------------------------------------------------------------------------
// ssrs_pkg
// Shared types and constants of the best single split search.
// ----------------------------------------------------------------------------
package ssrs_pkg;

  localparam int MAX_ACTIONS = 4;
  localparam int ACT_W = 2;
  localparam int SUM_W = 48;
  localparam int REW_W = 32;
  localparam int COV_W = 8;
  localparam int CNT_W = 3;
  localparam int IN_W = 2 + COV_W + REW_W + 4 * REW_W;
  localparam int IN_BYTES_W = 176;
  localparam int OUT_W = 1 + COV_W + REW_W + SUM_W + ACT_W + ACT_W + SUM_W + SUM_W + ACT_W;
  localparam int OUT_BYTES_W = 192;
  localparam logic [CNT_W-1:0] NUM_ACTIONS_RESET = 3'd2;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_TOTAL  = 2'd1,
    CMD_SCAN   = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  typedef logic signed [SUM_W-1:0] sum_t;

  // one decoded item passed from the front to the back
  typedef struct packed {
    cmd_t                     cmd;
    logic [COV_W-1:0]         cov;
    logic [REW_W-1:0]         x;
    logic [3:0][REW_W-1:0]    rew;
  } item_t;

  typedef struct packed {
    logic                     found;
    logic [COV_W-1:0]         cov;
    logic [REW_W-1:0]         value;
    sum_t                     total;
    logic [ACT_W-1:0]         lact;
    logic [ACT_W-1:0]         ract;
    sum_t                     lsum;
    sum_t                     rsum;
    logic [ACT_W-1:0]         leaf;
  } result_t;

  // saturating add/sub on 48-bit signed values
  function automatic sum_t sat_add(sum_t a, sum_t b);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                   : {1'b0, {(SUM_W-1){1'b1}}};
    else sat_add = s[SUM_W-1:0];
  endfunction

  function automatic sum_t sat_sub(sum_t a, sum_t b);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} - {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) sat_sub = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                   : {1'b0, {(SUM_W-1){1'b1}}};
    else sat_sub = s[SUM_W-1:0];
  endfunction

endpackage

/* src/ssrs_front.sv */
// ----------------------------------------------------------------------------
// ssrs_front
// Accepts items, decodes them and queues them in a two-entry fifo.
// ----------------------------------------------------------------------------
module ssrs_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ssrs_pkg::IN_W-1:0]       in_data,
  output logic                            q_valid,
  input  logic                            q_take,
  output ssrs_pkg::item_t                 q_item
);
  import ssrs_pkg::*;

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  item_t      dec;

  // field decode, tdata lowest bits first
  always_comb begin
    dec.cmd = cmd_t'(in_data[1:0]);
    dec.cov = in_data[9:2];
    dec.x   = in_data[41:10];
    for (int i = 0; i < 4; i++) dec.rew[i] = in_data[42 + i*REW_W +: REW_W];
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_item   = mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= dec;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* src/ssrs_back.sv */
// ----------------------------------------------------------------------------
// ssrs_back
// Carries out decoded items: sums, split evaluation and the result register.
// ----------------------------------------------------------------------------
module ssrs_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ssrs_pkg::CNT_W-1:0]  num_actions,
  input  logic                        q_valid,
  output logic                        q_take,
  input  ssrs_pkg::item_t             q_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ssrs_pkg::result_t           out_res
);
  import ssrs_pkg::*;

  sum_t                  tot [MAX_ACTIONS];
  sum_t                  lft [MAX_ACTIONS];
  logic [REW_W-1:0]      prev;
  logic                  have_prev;
  logic [COV_W-1:0]      cur_cov;
  sum_t                  best_total;
  sum_t                  best_lsum;
  sum_t                  best_rsum;
  logic                  best_found;
  logic [COV_W-1:0]      best_cov;
  logic [REW_W-1:0]      best_val;
  logic [ACT_W-1:0]      best_lact;
  logic [ACT_W-1:0]      best_ract;
  logic                  ns_ready;
  logic [ACT_W-1:0]      leaf;

  logic [CNT_W-1:0]      n;
  logic                  fire;
  sum_t                  rdiff [MAX_ACTIONS];
  sum_t                  lb, rb, tb, split_sum;
  logic [ACT_W-1:0]      la, ra, ta;

  assign q_take = !out_valid || out_ready;
  assign fire   = q_valid && q_take;

  // active lane count
  always_comb begin
    if (num_actions == '0) n = CNT_W'(1);
    else if (num_actions > CNT_W'(MAX_ACTIONS)) n = CNT_W'(MAX_ACTIONS);
    else n = num_actions;
  end

  // argmax of left, right and totals over active lanes
  always_comb begin
    for (int d = 0; d < MAX_ACTIONS; d++) rdiff[d] = sat_sub(tot[d], lft[d]);
    lb = lft[0]; rb = rdiff[0]; tb = tot[0];
    la = '0; ra = '0; ta = '0;
    for (int d = 1; d < MAX_ACTIONS; d++) begin
      if (CNT_W'(d) < n) begin
        if (lft[d] > lb) begin lb = lft[d]; la = ACT_W'(d); end
        if (rdiff[d] > rb) begin rb = rdiff[d]; ra = ACT_W'(d); end
        if (tot[d] > tb) begin tb = tot[d]; ta = ACT_W'(d); end
      end
    end
    split_sum = sat_add(lb, rb);
  end

  // item execution
  always_ff @(posedge clk) begin
    if (rst || (fire && q_item.cmd == CMD_START)) begin
      for (int d = 0; d < MAX_ACTIONS; d++) begin tot[d] <= '0; lft[d] <= '0; end
      prev <= '0; have_prev <= 1'b0; cur_cov <= '0;
      best_total <= '0; best_lsum <= '0; best_rsum <= '0;
      best_found <= 1'b0; best_cov <= '0; best_val <= '0;
      best_lact <= '0; best_ract <= '0; ns_ready <= 1'b0; leaf <= '0;
    end else if (fire) begin
      unique case (q_item.cmd) inside
        CMD_TOTAL: begin
          for (int d = 0; d < MAX_ACTIONS; d++)
            if (CNT_W'(d) < n) tot[d] <= sat_add(tot[d], sum_t'(signed'(q_item.rew[d])));
        end
        CMD_SCAN, CMD_FINISH: begin
          // no-split best and split eval never coincide on one item
          if (!ns_ready) begin
            best_total <= tb; leaf <= ta; ns_ready <= 1'b1;
          end
          if (q_item.cmd == CMD_SCAN) begin
            if (!have_prev || q_item.cov != cur_cov) begin
              for (int d = 0; d < MAX_ACTIONS; d++)
                lft[d] <= (CNT_W'(d) < n) ? sum_t'(signed'(q_item.rew[d])) : '0;
              cur_cov <= q_item.cov;
            end else begin
              if (q_item.x != prev && split_sum > best_total) begin
                best_total <= split_sum; best_lsum <= lb; best_rsum <= rb;
                best_found <= 1'b1; best_cov <= cur_cov; best_val <= prev;
                best_lact <= la; best_ract <= ra;
              end
              for (int d = 0; d < MAX_ACTIONS; d++)
                if (CNT_W'(d) < n) lft[d] <= sat_add(lft[d], sum_t'(signed'(q_item.rew[d])));
            end
            prev <= q_item.x;
            have_prev <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && q_item.cmd == CMD_FINISH) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && q_item.cmd == CMD_FINISH) begin
      out_res.found <= best_found;
      out_res.cov   <= best_found ? best_cov : '0;
      out_res.value <= best_found ? best_val : '0;
      out_res.total <= ns_ready ? best_total : tb;
      out_res.lact  <= best_found ? best_lact : '0;
      out_res.ract  <= best_found ? best_ract : '0;
      out_res.lsum  <= best_found ? best_lsum : '0;
      out_res.rsum  <= best_found ? best_rsum : '0;
      out_res.leaf  <= ns_ready ? leaf : ta;
    end
  end

endmodule

/* src/single_split_reward_search.sv */
// ----------------------------------------------------------------------------
// single_split_reward_search
// Best single split search of a policy stump over up to four reward lanes.
// ----------------------------------------------------------------------------
// flow: an accepted item is queued, then carried out when the back takes it,
// and a finish result is registered as the finish item is carried out
// throughput: one item per cycle while the back is free; the
// back holds while a finish result waits and the two-entry queue then fills
// reset: synchronous, clears all sums and bests; num_actions resets to 2
module single_split_reward_search (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // command, covariate, x_value, reward_a0..reward_a3, zero pad
  input  logic [ssrs_pkg::IN_BYTES_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // split_found, split_covariate, split_value, total_reward, left_action,
  // right_action, left_reward, right_reward, leaf_action, zero pad
  output logic [ssrs_pkg::OUT_BYTES_W-1:0]  m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ssrs_pkg::CNT_W-1:0]        cfg_data
);
  import ssrs_pkg::*;

  logic [CNT_W-1:0] num_actions;
  logic             q_valid;
  logic             q_take;
  item_t            q_item;
  result_t          res;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      num_actions <= NUM_ACTIONS_RESET;
    end else if (cfg_valid) begin
      num_actions <= cfg_data;
    end
  end

  ssrs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata[IN_W-1:0]),
    .q_valid  (q_valid),
    .q_take   (q_take),
    .q_item   (q_item)
  );

  ssrs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .num_actions (num_actions),
    .q_valid     (q_valid),
    .q_take      (q_take),
    .q_item      (q_item),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_res     (res)
  );

  // output packing, lowest field first
  assign m_axis_tdata = {(OUT_BYTES_W - OUT_W)'(0), res.leaf, res.rsum, res.lsum,
                         res.ract, res.lact, res.total, res.value, res.cov, res.found};

  // no split covariate or value without a found split
  a_nofound_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[40:1] == '0)
    else $error("split fields set without split");

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // input blocked only while the queue is not empty
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> q_valid)
    else $error("input stalled with empty queue");

endmodule

/* test/single_split_reward_search_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_split_reward_search_tb
// Drives command items into the split search, predicts each finish result
// with an in-bench model of the stump search and compares field by field.
// ----------------------------------------------------------------------------
module single_split_reward_search_tb;
  import ssrs_pkg::*;

  localparam logic signed [SUM_W-1:0] SMAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SMIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct {
    cmd_t             cmd;
    logic [7:0]       cov;
    logic [31:0]      x;
    logic [3:0][31:0] rew;
  } stim_t;

  typedef struct {
    logic        found;
    logic [7:0]  cov;
    logic [31:0] value;
    logic [47:0] total;
    logic [1:0]  lact;
    logic [1:0]  ract;
    logic [47:0] lsum;
    logic [47:0] rsum;
    logic [1:0]  leaf;
  } split_res_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_BYTES_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_BYTES_W-1:0] m_axis_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  single_split_reward_search uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [2:0] pm_nact;
  logic signed [47:0] pm_tot[4];
  logic signed [47:0] pm_left[4];
  logic [31:0] pm_prev;
  logic pm_have;
  logic [7:0] pm_cov;
  logic signed [47:0] pm_best, pm_bl, pm_br;
  logic pm_found;
  logic [7:0] pm_bcov;
  logic [31:0] pm_bval;
  logic [1:0] pm_bla, pm_bra, pm_leaf;
  logic pm_nsready;

  stim_t pending[$];
  split_res_t split_expected[$];
  int errors = 0;
  int hold_off = 0;
  bit stall_en = 1;

  function automatic logic signed [47:0] sat48(logic signed [49:0] v);
    if (v > 50'sd140737488355327) return SMAX;
    if (v < -50'sd140737488355328) return SMIN;
    return v[47:0];
  endfunction

  function automatic int lane_count();
    if (pm_nact == 0) return 1;
    if (pm_nact > MAX_ACTIONS) return MAX_ACTIONS;
    return int'(pm_nact);
  endfunction

  task automatic clear_search();
    for (int d = 0; d < 4; d++) begin
      pm_tot[d] = 0; pm_left[d] = 0;
    end
    pm_prev = 0; pm_have = 0; pm_cov = 0;
    pm_best = 0; pm_bl = 0; pm_br = 0; pm_found = 0;
    pm_bcov = 0; pm_bval = 0; pm_bla = 0; pm_bra = 0;
    pm_nsready = 0; pm_leaf = 0;
  endtask

  // try a split at the previous value
  task automatic try_split();
    int n;
    logic signed [47:0] lb, rb, r, s;
    logic [1:0] la, ra;
    n = lane_count();
    lb = pm_left[0]; rb = sat48(pm_tot[0] - pm_left[0]); la = 0; ra = 0;
    for (int d = 1; d < n; d++) begin
      r = sat48(pm_tot[d] - pm_left[d]);
      if (pm_left[d] > lb) begin lb = pm_left[d]; la = 2'(d); end
      if (r > rb) begin rb = r; ra = 2'(d); end
    end
    s = sat48(lb + rb);
    if (s > pm_best) begin
      pm_best = s; pm_bl = lb; pm_br = rb; pm_found = 1;
      pm_bcov = pm_cov; pm_bval = pm_prev; pm_bla = la; pm_bra = ra;
    end
  endtask

  task automatic predict_split(stim_t it);
    int n;
    split_res_t r;
    n = lane_count();
    case (it.cmd)
      CMD_START: clear_search();
      CMD_TOTAL: begin
        for (int d = 0; d < n; d++)
          pm_tot[d] = sat48(pm_tot[d] + $signed(it.rew[d]));
      end
      default: begin
        if (!pm_nsready) begin
          pm_best = pm_tot[0]; pm_leaf = 0;
          for (int d = 1; d < n; d++)
            if (pm_tot[d] > pm_best) begin pm_best = pm_tot[d]; pm_leaf = 2'(d); end
          pm_nsready = 1;
        end
        if (it.cmd == CMD_SCAN) begin
          if (!pm_have || it.cov != pm_cov) begin
            for (int d = 0; d < 4; d++) pm_left[d] = 0;
            pm_cov = it.cov;
          end else if (it.x != pm_prev) begin
            try_split();
          end
          for (int d = 0; d < n; d++)
            pm_left[d] = sat48(pm_left[d] + $signed(it.rew[d]));
          pm_prev = it.x; pm_have = 1;
        end else begin
          r.found = pm_found;
          r.cov = pm_found ? pm_bcov : '0;
          r.value = pm_found ? pm_bval : '0;
          r.total = pm_best;
          r.lact = pm_found ? pm_bla : '0;
          r.ract = pm_found ? pm_bra : '0;
          r.lsum = pm_found ? pm_bl : '0;
          r.rsum = pm_found ? pm_br : '0;
          r.leaf = pm_leaf;
          split_expected.push_back(r);
        end
      end
    endcase
  endtask

  function automatic logic [31:0] rand_reward();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 'h40000)) - 'sh20000;
    endcase
  endfunction

  function automatic stim_t mk(cmd_t c, logic [7:0] cv, logic [31:0] x,
                               logic [31:0] r0, logic [31:0] r1,
                               logic [31:0] r2, logic [31:0] r3);
    stim_t it;
    it.cmd = c; it.cov = cv; it.x = x;
    it.rew[0] = r0; it.rew[1] = r1; it.rew[2] = r2; it.rew[3] = r3;
    return it;
  endfunction

  function automatic stim_t rand_item(cmd_t c, logic [7:0] cv, logic [31:0] x);
    return mk(c, cv, x, rand_reward(), rand_reward(), rand_reward(), rand_reward());
  endfunction

  // driver
  always @(posedge clk) begin
    stim_t it;
    if (rst) begin
      s_axis_tvalid <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending.size() > 0 && $urandom_range(0, 9) < 7) begin
        it = pending.pop_front();
        predict_split(it);
        s_axis_tdata <= {6'd0, it.rew[3], it.rew[2], it.rew[1], it.rew[0],
                         it.x, it.cov, it.cmd};
        s_axis_tvalid <= 1;
      end else begin
        s_axis_tvalid <= 0;
        if (pending.size() > 0 && $urandom_range(0, 30) == 0)
          repeat ($urandom_range(5, 40)) @(posedge clk);
      end
    end
  end

  // receiver readiness with a long hold-off when one is set
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 0;
    end else if (!stall_en) begin
      m_axis_tready <= 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 9) < 7);
    end
  end

  // monitor
  always @(posedge clk) begin
    split_res_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (split_expected.size() == 0) begin
        $display("%0t unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        e = split_expected.pop_front();
        if (m_axis_tdata[0] !== e.found) begin
          $display("%0t split_found exp %h got %h", $time, e.found, m_axis_tdata[0]);
          errors++;
        end
        if (m_axis_tdata[8:1] !== e.cov) begin
          $display("%0t split_covariate exp %h got %h", $time, e.cov, m_axis_tdata[8:1]);
          errors++;
        end
        if (m_axis_tdata[40:9] !== e.value) begin
          $display("%0t split_value exp %h got %h", $time, e.value, m_axis_tdata[40:9]);
          errors++;
        end
        if (m_axis_tdata[88:41] !== e.total) begin
          $display("%0t total_reward exp %h got %h", $time, e.total, m_axis_tdata[88:41]);
          errors++;
        end
        if (m_axis_tdata[90:89] !== e.lact) begin
          $display("%0t left_action exp %h got %h", $time, e.lact, m_axis_tdata[90:89]);
          errors++;
        end
        if (m_axis_tdata[92:91] !== e.ract) begin
          $display("%0t right_action exp %h got %h", $time, e.ract, m_axis_tdata[92:91]);
          errors++;
        end
        if (m_axis_tdata[140:93] !== e.lsum) begin
          $display("%0t left_reward exp %h got %h", $time, e.lsum, m_axis_tdata[140:93]);
          errors++;
        end
        if (m_axis_tdata[188:141] !== e.rsum) begin
          $display("%0t right_reward exp %h got %h", $time, e.rsum, m_axis_tdata[188:141]);
          errors++;
        end
        if (m_axis_tdata[190:189] !== e.leaf) begin
          $display("%0t leaf_action exp %h got %h", $time, e.leaf, m_axis_tdata[190:189]);
          errors++;
        end
      end
    end
  end

  task automatic write_actions(logic [2:0] v);
    @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    pm_nact = v;
  endtask

  task automatic drain();
    while (pending.size() > 0 || s_axis_tvalid || split_expected.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // one random problem: totals then mostly ascending scans per covariate, then finish
  task automatic queue_problem(int npts);
    logic [31:0] x;
    logic [7:0] cv;
    int ncov;
    pending.push_back(mk(CMD_START, 8'($urandom), $urandom, $urandom, $urandom,
                         $urandom, $urandom));
    for (int i = 0; i < npts; i++)
      pending.push_back(rand_item(CMD_TOTAL, 8'($urandom), $urandom));
    ncov = $urandom_range(1, 3);
    cv = 8'($urandom);
    for (int c = 0; c < ncov; c++) begin
      x = $signed($urandom_range(0, 2000)) - 1000;
      for (int i = 0; i < npts; i++) begin
        if ($urandom_range(0, 19) == 0) x = $urandom;
        else if ($urandom_range(0, 2) != 0) x = x + $urandom_range(1, 500);
        pending.push_back(rand_item(CMD_SCAN, cv, x));
        if ($urandom_range(0, 25) == 0)
          pending.push_back(rand_item(CMD_TOTAL, 8'($urandom), $urandom));
        if ($urandom_range(0, 30) == 0)
          pending.push_back(rand_item(CMD_FINISH, 8'($urandom), $urandom));
      end
      cv = cv + 8'($urandom_range(1, 3));
    end
    pending.push_back(rand_item(CMD_FINISH, 8'($urandom), $urandom));
    if ($urandom_range(0, 3) == 0)
      pending.push_back(rand_item(CMD_FINISH, 8'($urandom), $urandom));
  endtask

  initial begin
    int sent;
    logic [2:0] settings[6];
    settings = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd3, 3'd2};
    pm_nact = NUM_ACTIONS_RESET;
    clear_search();
    repeat (10) @(posedge clk);
    rst <= 0;

    // directed: reset setting, extremes, ties, saturation, unsorted
    pending.push_back(mk(CMD_FINISH, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(CMD_START, 8'hff, 32'hffffffff, '1, '1, '1, '1));
    for (int i = 0; i < 4; i++)
      pending.push_back(mk(CMD_TOTAL, 0, 0, 32'h7fffffff, 32'h7fffffff,
                           32'h80000000, 32'h7fffffff));
    pending.push_back(mk(CMD_SCAN, 8'hff, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0));
    pending.push_back(mk(CMD_SCAN, 8'hff, 32'h80000000, 5, 5, 5, 5));
    pending.push_back(mk(CMD_SCAN, 8'hff, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0));
    pending.push_back(mk(CMD_SCAN, 8'hff, 32'h00000010, 1, 1, 0, 0));
    pending.push_back(mk(CMD_TOTAL, 0, 0, 32'h80000000, 32'h80000000, 0, 0));
    pending.push_back(mk(CMD_SCAN, 8'h00, 32'h00000000, 3, 3, 0, 0));
    pending.push_back(mk(CMD_SCAN, 8'h00, 32'h00000001, 3, 3, 0, 0));
    pending.push_back(mk(CMD_FINISH, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(CMD_SCAN, 8'h00, 32'h00000002, 32'h7fffffff, 0, 0, 0));
    pending.push_back(mk(CMD_FINISH, 0, 0, 0, 0, 0, 0));
    drain();

    // long receiver hold-off while the sender keeps going past a finish
    hold_off = 400;
    queue_problem(30);
    queue_problem(30);
    drain();

    // random phases over several lane counts
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_actions(settings[ph]);
      stall_en = (ph != 2);
      for (int p = 0; p < 5; p++) begin
        queue_problem($urandom_range(0, 9) == 0 ? 40 : $urandom_range(1, 10));
      end
      drain();
    end

    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

/* files.f */
src/ssrs_pkg.sv
src/ssrs_front.sv
src/ssrs_back.sv
src/single_split_reward_search.sv
test/single_split_reward_search_tb.sv
